// ----- sv/sall_pkg.sv -----
`timescale 1ns / 1ps

package sall_pkg;

  localparam int KEY_W  = 32;
  localparam int ACT_W  = 2;
  localparam int SLOT_W = 6;

  // Operation codes carried on the action field
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FREE_RD,
    ST_INS,
    ST_DEL,
    ST_PREV_WR,
    ST_DONE
  } st_t;

endpackage

// ----- sv/sorted_array_linked_list.sv -----
// Operation: the walk reads one list slot per cycle (one key/link memory read) until it meets
//   a key not smaller than the search key or the list end; the update states follow in order:
//   free slot read, insert or delete, previous link write. One beat at a time: the input stalls
//   while an operation is in progress. The next beat is taken while the result still waits.
// Reset: empty list, free chain in slot order from slot 0, fill count zero. No memory clearing
//   pass: link entries at or above the fill count read as their reset chain value.
`timescale 1ns / 1ps

module sorted_array_linked_list #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sall_pkg::ACT_W-1:0]         action,
  input  logic signed [sall_pkg::KEY_W-1:0]  key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               ok,
  output logic [sall_pkg::SLOT_W-1:0]        slot
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PTR_W = IDX_W + 1;
  localparam int EXT_W = (IDX_W > sall_pkg::SLOT_W) ? IDX_W : sall_pkg::SLOT_W;
  localparam logic [PTR_W-1:0] PTR_NULL = {PTR_W{1'b1}};
  localparam logic [PTR_W-1:0] PTR_CAP  = PTR_W'(CAPACITY);

  // Memories
  logic signed [sall_pkg::KEY_W-1:0] key_mem  [CAPACITY];
  logic        [PTR_W-1:0]           link_mem [CAPACITY];

  // Registers
  sall_pkg::st_t                     state, state_next;
  sall_pkg::act_t                    act_q;
  logic signed [sall_pkg::KEY_W-1:0] key_q;
  logic [PTR_W-1:0]                  list_head, free_head, hwm;
  logic [PTR_W-1:0]                  cur, prev, steps, wr_val;
  logic signed [sall_pkg::KEY_W-1:0] key_rd;
  logic [PTR_W-1:0]                  link_rd;
  logic [IDX_W-1:0]                  rd_addr;
  logic                              rd_fresh;
  logic                              res_ok;
  logic [IDX_W-1:0]                  res_slot;

  // Combinational control
  sall_pkg::act_t     act_c;
  logic               in_fire, out_free;
  logic [PTR_W-1:0]   link_eff, dflt_nxt, steps_inc;
  logic               less, wend, wfound;
  sall_pkg::st_t      disp_state;
  logic               rd_en, key_we, link_we;
  logic [IDX_W-1:0]   rd_addr_c, wr_idx;
  logic [PTR_W-1:0]   link_wdata;
  logic [EXT_W-1:0]   res_ext;

  assign in_stall  = (state != sall_pkg::ST_IDLE);
  assign in_fire   = in_valid && (state == sall_pkg::ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign act_c     = (state == sall_pkg::ST_IDLE) ? sall_pkg::act_t'(action) : act_q;
  assign steps_inc = steps + PTR_W'(1);
  assign res_ext   = EXT_W'(res_slot);

  // Link read data, with entries at or above the fill count taking their reset chain value
  always_comb begin
    dflt_nxt = {1'b0, rd_addr} + PTR_W'(1);
    if (dflt_nxt >= PTR_CAP) begin
      dflt_nxt = PTR_NULL;
    end
    link_eff = rd_fresh ? dflt_nxt : link_rd;
  end

  // Walk step: advance while the stored key is smaller
  always_comb begin
    less   = (key_rd < key_q);
    wend   = 1'b0;
    wfound = 1'b0;
    if (state == sall_pkg::ST_WALK) begin
      if (less) begin
        wend = (link_eff >= PTR_CAP) || (steps_inc >= PTR_CAP);
      end else begin
        wend   = 1'b1;
        wfound = (key_rd == key_q);
      end
    end
  end

  // Dispatch at the end of a walk
  always_comb begin
    case (act_c)
      sall_pkg::ACT_DELETE: disp_state = wfound ? sall_pkg::ST_DEL : sall_pkg::ST_DONE;
      sall_pkg::ACT_INSERT: disp_state = wfound ? sall_pkg::ST_DONE : sall_pkg::ST_FREE_RD;
      default:              disp_state = sall_pkg::ST_DONE;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sall_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (act_c == sall_pkg::ACT_CLEAR) begin
            state_next = sall_pkg::ST_DONE;
          end else if (act_c == sall_pkg::ACT_INSERT && free_head >= PTR_CAP) begin
            state_next = sall_pkg::ST_DONE;
          end else if (list_head >= PTR_CAP) begin
            state_next = disp_state;
          end else begin
            state_next = sall_pkg::ST_WALK;
          end
        end
      end
      sall_pkg::ST_WALK: begin
        if (wend) begin
          state_next = disp_state;
        end
      end
      sall_pkg::ST_FREE_RD: state_next = sall_pkg::ST_INS;
      sall_pkg::ST_INS,
      sall_pkg::ST_DEL: begin
        state_next = (prev >= PTR_CAP) ? sall_pkg::ST_DONE : sall_pkg::ST_PREV_WR;
      end
      sall_pkg::ST_PREV_WR: state_next = sall_pkg::ST_DONE;
      sall_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = sall_pkg::ST_IDLE;
        end
      end
      default: state_next = sall_pkg::ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_en      = 1'b0;
    rd_addr_c  = list_head[IDX_W-1:0];
    key_we     = 1'b0;
    link_we    = 1'b0;
    wr_idx     = free_head[IDX_W-1:0];
    link_wdata = wr_val;
    case (state)
      sall_pkg::ST_IDLE: begin
        rd_en = in_valid && (state_next == sall_pkg::ST_WALK);
      end
      sall_pkg::ST_WALK: begin
        rd_en     = less && !wend;
        rd_addr_c = link_eff[IDX_W-1:0];
      end
      sall_pkg::ST_FREE_RD: begin
        rd_en     = 1'b1;
        rd_addr_c = free_head[IDX_W-1:0];
      end
      sall_pkg::ST_INS: begin
        key_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = (prev >= PTR_CAP) ? list_head : cur;
      end
      sall_pkg::ST_DEL: begin
        link_we    = 1'b1;
        wr_idx     = cur[IDX_W-1:0];
        link_wdata = free_head;
      end
      sall_pkg::ST_PREV_WR: begin
        link_we = 1'b1;
        wr_idx  = prev[IDX_W-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (rd_en) begin
      key_rd <= key_mem[rd_addr_c];
    end
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_idx] <= link_wdata;
    end
    if (rd_en) begin
      link_rd  <= link_mem[rd_addr_c];
      rd_addr  <= rd_addr_c;
      rd_fresh <= ({1'b0, rd_addr_c} >= hwm);
    end
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_q <= act_c;
      key_q <= key;
      cur   <= list_head;
      prev  <= PTR_NULL;
      steps <= '0;
    end
    if (state == sall_pkg::ST_WALK && less) begin
      prev  <= cur;
      cur   <= link_eff;
      steps <= steps_inc;
    end
    if ((in_fire && state_next != sall_pkg::ST_WALK) || wend) begin
      res_ok   <= (act_c == sall_pkg::ACT_CLEAR) || (act_c == sall_pkg::ACT_SEARCH && wfound);
      res_slot <= (act_c == sall_pkg::ACT_SEARCH && wfound) ? cur[IDX_W-1:0] : '0;
    end
    if (state == sall_pkg::ST_INS) begin
      res_ok   <= 1'b1;
      res_slot <= free_head[IDX_W-1:0];
      wr_val   <= free_head;
    end
    if (state == sall_pkg::ST_DEL) begin
      res_ok   <= 1'b1;
      res_slot <= cur[IDX_W-1:0];
      wr_val   <= link_eff;
    end
  end

  // List heads, fill count, sequencer and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sall_pkg::ST_IDLE;
      list_head <= PTR_NULL;
      free_head <= '0;
      hwm       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // rebuild empty list and full free chain
      if (in_fire && act_c == sall_pkg::ACT_CLEAR) begin
        list_head <= PTR_NULL;
        free_head <= '0;
        hwm       <= '0;
      end
      // take the free slot and link it in
      if (state == sall_pkg::ST_INS) begin
        free_head <= link_eff;
        if (free_head == hwm) begin
          hwm <= hwm + PTR_W'(1);
        end
        if (prev >= PTR_CAP) begin
          list_head <= free_head;
        end
      end
      // unlink and push the slot on the free chain
      if (state == sall_pkg::ST_DEL) begin
        free_head <= cur;
        if (prev >= PTR_CAP) begin
          list_head <= link_eff;
        end
      end
      // hold the result beat until taken
      if (state == sall_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sall_pkg::ST_DONE && out_free) begin
      ok   <= res_ok;
      slot <= res_ext[sall_pkg::SLOT_W-1:0];
    end
  end

  // Checks
  a_hwm_bound: assert property (@(posedge clk) disable iff (rst) hwm <= PTR_CAP)
    else $error("fill count beyond capacity");

  a_walk_addr: assert property (@(posedge clk) disable iff (rst)
    state == sall_pkg::ST_WALK |-> (rd_addr == cur[IDX_W-1:0] && cur < PTR_CAP))
    else $error("walk data does not match current slot");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == sall_pkg::ST_WALK |-> steps < PTR_CAP)
    else $error("walk ran past capacity");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> slot == '0)
    else $error("failed beat carries a slot");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CAP         = 64;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT = 4000;  // cycles without any beat before giving up
  localparam int SETTLE      = CAP + 40;

  typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

  typedef struct {
    sall_pkg::act_t                     act;
    logic signed [sall_pkg::KEY_W-1:0]  key;
  } op_beat_t;

  typedef struct {
    sall_pkg::act_t                     act;
    logic signed [sall_pkg::KEY_W-1:0]  key;
    logic                               ok;
    logic [sall_pkg::SLOT_W-1:0]        slot;
  } reply_t;

  logic                               clk;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [sall_pkg::ACT_W-1:0]         action = sall_pkg::ACT_INSERT;
  logic signed [sall_pkg::KEY_W-1:0]  key = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               ok;
  logic [sall_pkg::SLOT_W-1:0]        slot;

  sorted_array_linked_list #(.CAPACITY(CAP)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .key(key),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok), .slot(slot)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the list: keys, links, list head and free head
  logic signed [sall_pkg::KEY_W-1:0] shadow_key [CAP];
  int                                shadow_link [CAP];
  int                                shadow_head;
  int                                shadow_free;

  op_beat_t                          pend_q[$];
  reply_t                            reply_q[$];
  logic signed [sall_pkg::KEY_W-1:0] key_pool[$];

  pace_t pace = PACE_FREE;
  int    hold_ask = 0;
  int    hold_served = 0;
  int    hold_left = 0;
  logic  in_took = 1'b0;
  int    quiet = 0;
  int    errors = 0;
  int    checked = 0;
  int    full_refusals = 0;
  int    beats_per_act [4];
  int    hits_per_act [4];

  function automatic bit is_null(int p);
    return (p < 0) || (p >= CAP);
  endfunction

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Empty list, free chain through every slot in order
  function automatic void shadow_rebuild();
    for (int i = 0; i < CAP; i++)
      shadow_link[i] = (i + 1 < CAP) ? i + 1 : -1;
    shadow_head = -1;
    shadow_free = 0;
  endfunction

  // Apply one operation to the shadow list and return the reply it gives
  function automatic reply_t list_step(op_beat_t b);
    reply_t r;
    int     p;
    int     prev;
    int     s;
    int     steps;
    bit     hit;
    r.act  = b.act;
    r.key  = b.key;
    r.ok   = 1'b0;
    r.slot = '0;
    if (b.act == sall_pkg::ACT_CLEAR) begin
      shadow_rebuild();
      r.ok = 1'b1;
    end else begin
      // walk past every smaller key
      prev  = -1;
      p     = shadow_head;
      steps = 0;
      while (!is_null(p) && steps < CAP && shadow_key[p] < b.key) begin
        prev = p;
        p    = shadow_link[p];
        steps++;
      end
      if (steps >= CAP)
        p = -1;
      hit = !is_null(p) && (shadow_key[p] == b.key);
      case (b.act)
        sall_pkg::ACT_SEARCH: begin
          if (hit) begin
            r.ok   = 1'b1;
            r.slot = p[sall_pkg::SLOT_W-1:0];
          end
        end
        sall_pkg::ACT_DELETE: begin
          if (hit) begin
            if (is_null(prev))
              shadow_head = shadow_link[p];
            else
              shadow_link[prev] = shadow_link[p];
            shadow_link[p] = shadow_free;
            shadow_free    = p;
            r.ok   = 1'b1;
            r.slot = p[sall_pkg::SLOT_W-1:0];
          end
        end
        default: begin
          if (is_null(shadow_free)) begin
            full_refusals++;
          end else if (!hit) begin
            s            = shadow_free;
            shadow_free  = shadow_link[s];
            shadow_key[s] = b.key;
            if (is_null(prev)) begin
              shadow_link[s] = shadow_head;
              shadow_head    = s;
            end else begin
              shadow_link[s]    = shadow_link[prev];
              shadow_link[prev] = s;
            end
            r.ok   = 1'b1;
            r.slot = s[sall_pkg::SLOT_W-1:0];
          end
        end
      endcase
    end
    return r;
  endfunction

  // Stimulus helpers
  task automatic push_op(sall_pkg::act_t a, logic signed [sall_pkg::KEY_W-1:0] k);
    op_beat_t b;
    b.act = a;
    b.key = k;
    pend_q.push_back(b);
    if (a == sall_pkg::ACT_INSERT) begin
      key_pool.push_back(k);
      if (key_pool.size() > 200)
        void'(key_pool.pop_front());
    end
  endtask

  function automatic logic signed [sall_pkg::KEY_W-1:0] fresh_key();
    logic signed [sall_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0:       k = 32'sh8000_0000;
      1:       k = 32'sh7fff_ffff;
      2:       k = 32'sd0;
      3:       k = -32'sd1;
      4, 5:    k = int'($urandom_range(0, 40)) - 20;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic logic signed [sall_pkg::KEY_W-1:0] pool_key(int pct);
    if (key_pool.size() > 0 && roll(pct))
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return fresh_key();
  endfunction

  // Wait until the block has drained every beat handed to it
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || reply_q.size() != 0)
      @(posedge clk);
  endtask

  // Fill the list past capacity, then free and reuse a few slots
  task automatic push_fill();
    push_op(sall_pkg::ACT_CLEAR, $urandom);
    for (int i = 0; i < CAP + 3; i++)
      push_op(sall_pkg::ACT_INSERT, roll(90) ? $urandom : fresh_key());
    push_op(sall_pkg::ACT_INSERT, pool_key(100));
    push_op(sall_pkg::ACT_SEARCH, pool_key(100));
    push_op(sall_pkg::ACT_SEARCH, pool_key(100));
    for (int i = 0; i < 3; i++)
      push_op(sall_pkg::ACT_DELETE, pool_key(100));
    push_op(sall_pkg::ACT_INSERT, $urandom);
    push_op(sall_pkg::ACT_INSERT, $urandom);
  endtask

  task automatic push_chunk(int n, bit with_fill);
    int start;
    int pick;
    start = pend_q.size();
    if (with_fill)
      push_fill();
    while (pend_q.size() - start < n) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed mix: grow the list and hit keys it holds
        for (int i = 0; i < 12; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 42)
            push_op(sall_pkg::ACT_INSERT, pool_key(25));
          else if (pick < 68)
            push_op(sall_pkg::ACT_DELETE, pool_key(80));
          else
            push_op(sall_pkg::ACT_SEARCH, pool_key(70));
        end
      end else begin
        // noise: any action, any key
        for (int i = 0; i < 6; i++)
          push_op(sall_pkg::act_t'($urandom_range(0, 3)), fresh_key());
      end
    end
  endtask

  // Driver: present the next beat at the falling edge, hold it while stalled
  always @(negedge clk) begin : drive
    op_beat_t nxt;
    bit       idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      case (pace)
        PACE_SRC_IDLE: idle = roll(84);
        PACE_BOTH:     idle = roll(9);
        default:       idle = 1'b0;
      endcase
      if (pend_q.size() != 0 && !idle) begin
        nxt = pend_q.pop_front();
        in_valid <= 1'b1;
        action   <= nxt.act;
        key      <= nxt.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_served) begin
      hold_served <= hold_ask;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      case (pace)
        PACE_SNK_STALL: out_stall <= roll(84);
        PACE_BOTH:      out_stall <= roll(9);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : monitor
    op_beat_t got_op;
    reply_t   want;
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        got_op.act = sall_pkg::act_t'(action);
        got_op.key = key;
        want = list_step(got_op);
        beats_per_act[int'(want.act)]++;
        if (want.ok && want.act != sall_pkg::ACT_CLEAR && want.act != sall_pkg::ACT_INSERT)
          hits_per_act[int'(want.act)]++;
        reply_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: ok %0d slot %0d",
                   $time, ok, slot);
        end else begin
          want = reply_q.pop_front();
          if (ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch, action %0d key %0d: expected %0d, got %0d",
                     $time, want.act, want.key, want.ok, ok);
          end
          if (slot !== want.slot) begin
            errors++;
            $display("%0t: slot mismatch, action %0d key %0d: expected %0d, got %0d",
                     $time, want.act, want.key, want.slot, slot);
          end
        end
      end
    end
  end

  // Watchdog: stop if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    shadow_rebuild();
    for (int i = 0; i < 4; i++) begin
      beats_per_act[i] = 0;
      hits_per_act[i]  = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty list, extremes, head/middle/tail removal, slot reuse, clear
    push_op(sall_pkg::ACT_SEARCH, 32'sd5);
    push_op(sall_pkg::ACT_DELETE, 32'sd5);
    push_op(sall_pkg::ACT_INSERT, 32'sh7fff_ffff);
    push_op(sall_pkg::ACT_INSERT, 32'sh8000_0000);
    push_op(sall_pkg::ACT_INSERT, 32'sd0);
    push_op(sall_pkg::ACT_INSERT, -32'sd1);
    push_op(sall_pkg::ACT_INSERT, 32'sh7fff_ffff);
    push_op(sall_pkg::ACT_INSERT, 32'sh8000_0000);
    push_op(sall_pkg::ACT_SEARCH, 32'sh8000_0000);
    push_op(sall_pkg::ACT_SEARCH, 32'sh7fff_ffff);
    push_op(sall_pkg::ACT_SEARCH, 32'sd1);
    push_op(sall_pkg::ACT_DELETE, 32'sd0);
    push_op(sall_pkg::ACT_DELETE, 32'sh8000_0000);
    push_op(sall_pkg::ACT_DELETE, 32'sh7fff_ffff);
    push_op(sall_pkg::ACT_DELETE, 32'sh7fff_ffff);
    push_op(sall_pkg::ACT_INSERT, 32'sd1);
    push_op(sall_pkg::ACT_INSERT, 32'sh5555_aaaa);
    push_op(sall_pkg::ACT_SEARCH, -32'sd1);
    push_op(sall_pkg::ACT_CLEAR, 32'shffff_ffff);
    push_op(sall_pkg::ACT_SEARCH, -32'sd1);
    push_op(sall_pkg::ACT_INSERT, 32'shaaaa_5555);
    push_op(sall_pkg::ACT_CLEAR, 32'sd0);
    wait_idle();

    // Random phases; the sender pauses for a full drain between each
    for (int c = 0; c < 8; c++) begin
      pace = pace_t'(c % 4);
      if (c == 2 || c == 5)
        hold_ask = hold_ask + 1;
      push_chunk(72, c == 1 || c == 6);
      wait_idle();
    end

    repeat (SETTLE) @(posedge clk);
    if (reply_q.size() != 0) begin
      errors += reply_q.size();
      $display("%0t: %0d expected results never arrived", $time, reply_q.size());
    end
    $display("Covered %0d inserts (%0d refused on a full list), %0d deletes, %0d searches,",
             beats_per_act[sall_pkg::ACT_INSERT], full_refusals,
             beats_per_act[sall_pkg::ACT_DELETE], beats_per_act[sall_pkg::ACT_SEARCH]);
    $display("%0d clears; %0d results checked, %0d delete hits, %0d search hits, %0d errors",
             beats_per_act[sall_pkg::ACT_CLEAR], checked, hits_per_act[sall_pkg::ACT_DELETE],
             hits_per_act[sall_pkg::ACT_SEARCH], errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
